>>> src/skvt_pkg.sv
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants, types and hash functions of the string key-value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int TableEntriesDef = 64;
    localparam int MaxKeyBytesDef  = 49;

    localparam int ByteW   = 7;
    localparam int HashW   = 32;
    localparam int SalaryW = 32;
    localparam int StatusW = 3;
    localparam int OpW     = 2;

    typedef enum logic [OpW-1:0] {
        OP_PUT    = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_SPARE  = 2'd3
    } t_op;

    typedef enum logic [StatusW-1:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_FULL      = 3'd5,
        ST_TOO_LONG  = 3'd6
    } t_status;

    // one step of the one-at-a-time mix
    function automatic logic [HashW-1:0] hash_mix(input logic [HashW-1:0] h,
                                                  input logic [ByteW-1:0] c);
        logic [HashW-1:0] t;
        t = h + {{(HashW-ByteW){1'b0}}, c};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [HashW-1:0] hash_final(input logic [HashW-1:0] h);
        logic [HashW-1:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

>>> src/string_key_value_table_core.sv
// ----------------------------------------------------------------------------
// string_key_value_table_core
// Name-keyed table with one-at-a-time hashing; insert/update, delete, search.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                         | tuser      | tlast
// --------+-----+-------------------------------+------------+----------
// slave   | in  | [6:0] name_byte [38:7] salary | req_type   | last_byte
// master  | out | [31:0] key_hash [63:32] salary| status     | -
//
// Name bytes are taken one per cycle while the core is idle. The last byte
// starts a walk over the table entries that stops at the first match: the
// metadata of each entry is read, and the stored name is compared byte by
// byte when hash and length agree. A name that is too long skips the walk.
// An insert copies the key byte by byte into the name RAM. The request time
// is set by the single read port of the metadata and name RAMs.
// After reset the metadata RAM is cleared, one entry per cycle, over all
// TABLE_ENTRIES entries; no request is taken meanwhile.
// A stalled result stays in the output register; new name bytes are taken
// while it waits, and only the next lookup result waits for it to drain.
// ----------------------------------------------------------------------------
module string_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDef,
    parameter int MAX_KEY_BYTES = MaxKeyBytesDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request side
    input  logic                       i_tvalid,
    output logic                       o_tready,
    input  logic [39:0]                i_tdata,   // name_byte, salary, pad
    input  logic [OpW-1:0]             i_tuser,   // req_type
    input  logic                       i_tlast,   // last_byte
    // result side
    output logic                       o_tvalid,
    input  logic                       i_tready,
    output logic [HashW+SalaryW-1:0]   o_tdata,   // key_hash, found_salary
    output logic [StatusW-1:0]         o_tuser    // status
);

    localparam int IdxW  = $clog2(TABLE_ENTRIES);
    localparam int LenW  = $clog2(MAX_KEY_BYTES + 1);
    localparam int KAddW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int NameD = TABLE_ENTRIES * MAX_KEY_BYTES;
    localparam int NAddW = $clog2(NameD);
    localparam int MetaW = 1 + LenW + HashW + SalaryW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FIN, S_MRD, S_MCHK, S_CRD, S_CCHK,
        S_ACT, S_CPRD, S_CPWR, S_DONE
    } t_state;

    t_state               r_state;
    logic [IdxW-1:0]      r_idx;
    logic [IdxW-1:0]      r_tgt;
    logic [LenW-1:0]      r_pos;
    logic [LenW-1:0]      r_count;
    logic                 r_ovf;
    logic [HashW-1:0]     r_hash;
    logic [HashW-1:0]     r_fin;
    t_op                  r_op;
    logic [SalaryW-1:0]   r_sal;
    logic [SalaryW-1:0]   r_msal;   // salary of the matched entry
    logic                 r_hit;
    logic                 r_free_ok;
    t_status              r_status;
    logic [SalaryW-1:0]   r_fsal;
    logic                 r_out_valid;
    logic [StatusW-1:0]   r_out_status;
    logic [HashW+SalaryW-1:0] r_out_data;

    logic [ByteW-1:0]     in_byte;
    logic [SalaryW-1:0]   in_sal;
    logic                 in_acc;
    logic [HashW-1:0]     n_hash;

    // memory ports
    logic                 kb_we;
    logic [ByteW-1:0]     kb_rdata;
    logic                 md_we;
    logic [IdxW-1:0]      md_waddr;
    logic [MetaW-1:0]     md_wdata;
    logic [MetaW-1:0]     md_rdata;
    logic                 nm_we;
    logic [NAddW-1:0]     nm_waddr;
    logic [NAddW-1:0]     nm_raddr;
    logic [ByteW-1:0]     nm_rdata;

    logic                 md_valid;
    logic [LenW-1:0]      md_len;
    logic [HashW-1:0]     md_hash;
    logic [SalaryW-1:0]   md_sal;
    logic                 last_idx;

    assign in_byte  = i_tdata[ByteW-1:0];
    assign in_sal   = i_tdata[ByteW+SalaryW-1:ByteW];
    assign o_tready = (r_state == S_IDLE);
    assign in_acc   = i_tvalid && o_tready;
    assign n_hash   = hash_mix(r_hash, in_byte);

    assign {md_valid, md_len, md_hash, md_sal} = md_rdata;
    assign last_idx = (r_idx == IdxW'(TABLE_ENTRIES - 1));

    assign kb_we    = in_acc && (r_count < LenW'(MAX_KEY_BYTES));
    assign nm_raddr = NAddW'(r_idx) * NAddW'(MAX_KEY_BYTES) + NAddW'(r_pos);
    assign nm_waddr = NAddW'(r_tgt) * NAddW'(MAX_KEY_BYTES) + NAddW'(r_pos);
    assign nm_we    = (r_state == S_CPWR);

    // metadata writes: clearing pass, update, delete, end of insert copy
    always_comb begin
        md_we    = 1'b0;
        md_waddr = r_tgt;
        md_wdata = {1'b1, r_count, r_fin, r_sal};
        case (r_state)
            S_CLR: begin
                md_we    = 1'b1;
                md_waddr = r_idx;
                md_wdata = '0;
            end
            S_ACT: begin
                if (r_hit && r_op == OP_PUT) begin
                    md_we = 1'b1;
                end else if (r_hit && r_op == OP_DELETE) begin
                    md_we    = 1'b1;
                    md_wdata = {1'b0, r_count, r_fin, r_msal};
                end
            end
            S_CPWR: begin
                md_we = (r_pos == r_count - LenW'(1));
            end
            default: begin
                md_we = 1'b0;
            end
        endcase
    end

    skvt_ram #(.Width(ByteW), .Depth(MAX_KEY_BYTES)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (kb_we),
        .i_waddr(r_count[KAddW-1:0]),
        .i_wdata(in_byte),
        .i_raddr(r_pos[KAddW-1:0]),
        .o_rdata(kb_rdata)
    );

    skvt_ram #(.Width(MetaW), .Depth(TABLE_ENTRIES)) u_meta_ram (
        .i_clk  (i_clk),
        .i_we   (md_we),
        .i_waddr(md_waddr),
        .i_wdata(md_wdata),
        .i_raddr(r_idx),
        .o_rdata(md_rdata)
    );

    skvt_ram #(.Width(ByteW), .Depth(NameD)) u_name_ram (
        .i_clk  (i_clk),
        .i_we   (nm_we),
        .i_waddr(nm_waddr),
        .i_wdata(kb_rdata),
        .i_raddr(nm_raddr),
        .o_rdata(nm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hash      <= '0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the output register itself
            if (i_tready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + IdxW'(1);
                    if (last_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_hash <= n_hash;
                        if (r_count < LenW'(MAX_KEY_BYTES)) begin
                            r_count <= r_count + LenW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_tlast) begin
                            r_op      <= t_op'(i_tuser);
                            r_sal     <= in_sal;
                            r_idx     <= '0;
                            r_hit     <= 1'b0;
                            r_free_ok <= 1'b0;
                            r_state   <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_fin  <= hash_final(r_hash);
                    r_hash <= '0;
                    if (r_ovf) begin
                        r_status <= ST_TOO_LONG;
                        r_fsal   <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MCHK;
                end
                S_MCHK: begin
                    if (md_valid && md_len == r_count && md_hash == r_fin) begin
                        r_msal  <= md_sal;
                        r_pos   <= '0;
                        r_state <= S_CRD;
                    end else begin
                        if (!md_valid && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_tgt     <= r_idx;
                        end
                        if (last_idx) begin
                            r_state <= S_ACT;
                        end else begin
                            r_idx   <= r_idx + IdxW'(1);
                            r_state <= S_MRD;
                        end
                    end
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                S_CCHK: begin
                    if (kb_rdata == nm_rdata) begin
                        if (r_pos == r_count - LenW'(1)) begin
                            r_hit   <= 1'b1;
                            r_tgt   <= r_idx;
                            r_state <= S_ACT;
                        end else begin
                            r_pos   <= r_pos + LenW'(1);
                            r_state <= S_CRD;
                        end
                    end else if (last_idx) begin
                        r_state <= S_ACT;
                    end else begin
                        r_idx   <= r_idx + IdxW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_ACT: begin
                    r_state <= S_DONE;
                    r_fsal  <= '0;
                    case (r_op)
                        OP_PUT: begin
                            if (r_hit) begin
                                r_status <= ST_UPDATED;
                                r_fsal   <= r_sal;
                            end else if (r_free_ok) begin
                                r_pos   <= '0;
                                r_state <= S_CPRD;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            r_status <= r_hit ? ST_DELETED : ST_NOT_FOUND;
                            if (r_hit) begin
                                r_fsal <= r_msal;
                            end
                        end
                        default: begin
                            r_status <= r_hit ? ST_FOUND : ST_NOT_FOUND;
                            if (r_hit) begin
                                r_fsal <= r_msal;
                            end
                        end
                    endcase
                end
                S_CPRD: begin
                    r_state <= S_CPWR;
                end
                S_CPWR: begin
                    if (r_pos == r_count - LenW'(1)) begin
                        r_status <= ST_INSERTED;
                        r_fsal   <= r_sal;
                        r_state  <= S_DONE;
                    end else begin
                        r_pos   <= r_pos + LenW'(1);
                        r_state <= S_CPRD;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_data   <= {r_fsal, r_fin};
                        r_count      <= '0;
                        r_ovf        <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_status;

endmodule

>>> src/skvt_ram.sv
// ----------------------------------------------------------------------------
// skvt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module skvt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AddrW-1:0] i_waddr,
    input  logic [Width-1:0] i_wdata,
    input  logic [AddrW-1:0] i_raddr,
    output logic [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/skvt_checker.sv
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level assertions for the string key-value table, bound to the core.
// ----------------------------------------------------------------------------
module skvt_checker
    import skvt_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_tvalid,
    input logic                     o_tready,
    input logic                     i_tlast,
    input logic                     o_tvalid,
    input logic                     i_tready,
    input logic [HashW+SalaryW-1:0] o_tdata,
    input logic [StatusW-1:0]       o_tuser
);

    // held result must not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && !i_tready |=> o_tvalid && $stable(o_tdata) && $stable(o_tuser))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_tvalid)
        else $error("result valid after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid |-> o_tuser <= ST_TOO_LONG)
        else $error("status code out of range");

    a_zero_sal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tvalid && (o_tuser == ST_NOT_FOUND || o_tuser == ST_FULL ||
                     o_tuser == ST_TOO_LONG) |-> o_tdata[HashW+SalaryW-1:HashW] == '0)
        else $error("salary not zero on a miss");

    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && o_tready && !i_tlast |=> !$rose(o_tvalid))
        else $error("result without a last byte");

endmodule

bind string_key_value_table_core skvt_checker u_skvt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_tvalid(i_tvalid),
    .o_tready(o_tready),
    .i_tlast (i_tlast),
    .o_tvalid(o_tvalid),
    .i_tready(i_tready),
    .o_tdata (o_tdata),
    .o_tuser (o_tuser)
);

>>> verif/tb_string_key_value_table_core.sv
// ----------------------------------------------------------------------------
// tb_string_key_value_table_core
// Streams key names into the table core and checks every lookup result
// against a local table model: status, finalized hash and salary.
// ----------------------------------------------------------------------------
module tb_string_key_value_table_core;
    import skvt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NumEntries = TableEntriesDef;
    localparam int MaxKey     = MaxKeyBytesDef;
    localparam int CycleLimit = 2000000;

    // one name byte request as driven on the slave side
    typedef struct packed {
        t_op              op;
        logic [ByteW-1:0] ch;
        logic             last;
        logic [31:0]      sal;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] hash;
        logic [31:0] sal;
    } t_rsp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_tvalid;
    logic        o_tready;
    logic [39:0] i_tdata;
    logic [1:0]  i_tuser;
    logic        i_tlast;
    logic        o_tvalid;
    logic        i_tready;
    logic [63:0] o_tdata;
    logic [2:0]  o_tuser;

    string_key_value_table_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tvalid(i_tvalid),
        .o_tready(o_tready),
        .i_tdata (i_tdata),
        .i_tuser (i_tuser),
        .i_tlast (i_tlast),
        .o_tvalid(o_tvalid),
        .i_tready(i_tready),
        .o_tdata (o_tdata),
        .o_tuser (o_tuser)
    );

    // Table model state
    logic [ByteW-1:0] name_buf [MaxKey];
    int               name_len;
    logic [31:0]      hash_acc;
    logic             name_ovf;
    logic             tbl_valid [NumEntries];
    logic [ByteW-1:0] tbl_name [NumEntries][MaxKey];
    int               tbl_len [NumEntries];
    logic [31:0]      tbl_sal [NumEntries];

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    longint cycles = 0;
    int   in_gap = 0;
    int   out_gap = 0;

    // Names reused so that updates, deletes and hits really happen
    logic [ByteW-1:0] pool_name [16][MaxKey + 4];
    int               pool_len [16];

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [31:0] oaat_mix(logic [31:0] h, logic [ByteW-1:0] c);
        logic [31:0] t;
        t = h + 32'(c);
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] oaat_final(logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

    // Applies one accepted request to the table model
    task automatic apply_table_req(input t_req r);
        int     idx;
        int     k;
        bit     same;
        t_rsp   x;
        hash_acc = oaat_mix(hash_acc, r.ch);
        if (name_len < MaxKey) begin
            name_buf[name_len] = r.ch;
            name_len++;
        end else begin
            name_ovf = 1'b1;
        end
        if (!r.last) return;
        x.hash = oaat_final(hash_acc);
        x.sal  = '0;
        if (name_ovf) begin
            x.status = ST_TOO_LONG;
        end else begin
            idx = -1;
            for (int i = 0; i < NumEntries && idx < 0; i++) begin
                if (tbl_valid[i] && tbl_len[i] == name_len) begin
                    same = 1;
                    for (k = 0; k < name_len; k++)
                        if (tbl_name[i][k] != name_buf[k]) same = 0;
                    if (same) idx = i;
                end
            end
            if (r.op == OP_PUT) begin
                if (idx >= 0) begin
                    tbl_sal[idx] = r.sal;
                    x.status = ST_UPDATED;
                    x.sal = r.sal;
                end else begin
                    for (int i = 0; i < NumEntries && idx < 0; i++)
                        if (!tbl_valid[i]) idx = i;
                    if (idx < 0) begin
                        x.status = ST_FULL;
                    end else begin
                        tbl_valid[idx] = 1'b1;
                        for (k = 0; k < name_len; k++) tbl_name[idx][k] = name_buf[k];
                        tbl_len[idx] = name_len;
                        tbl_sal[idx] = r.sal;
                        x.status = ST_INSERTED;
                        x.sal = r.sal;
                    end
                end
            end else if (r.op == OP_DELETE) begin
                if (idx >= 0) begin
                    tbl_valid[idx] = 1'b0;
                    x.status = ST_DELETED;
                    x.sal = tbl_sal[idx];
                end else begin
                    x.status = ST_NOT_FOUND;
                end
            end else begin
                if (idx >= 0) begin
                    x.status = ST_FOUND;
                    x.sal = tbl_sal[idx];
                end else begin
                    x.status = ST_NOT_FOUND;
                end
            end
        end
        expected_rsps.push_back(x);
        name_len = 0;
        hash_acc = '0;
        name_ovf = 1'b0;
    endtask

    // Queues a whole name; op and salary are random on all but the last byte
    task automatic queue_name(input logic [ByteW-1:0] nm [MaxKey + 4], input int len,
                              input t_op op, input logic [31:0] sal);
        t_req r;
        for (int k = 0; k < len; k++) begin
            r.op   = (k == len - 1) ? op : t_op'($urandom_range(0, 3));
            r.ch   = nm[k];
            r.last = (k == len - 1);
            r.sal  = (k == len - 1) ? sal : $urandom;
            pending_reqs.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Driver: one request per handshake, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_tvalid <= 1'b0;
        end else if (!i_tvalid || o_tready) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                t_req r;
                r = pending_reqs.pop_front();
                i_tvalid <= 1'b1;
                i_tdata  <= {1'b0, r.sal, r.ch};
                i_tuser  <= r.op;
                i_tlast  <= r.last;
                in_gap   <= pick_gap();
            end else begin
                i_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: model on request acceptance, compare on result acceptance
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_tvalid && o_tready)
                apply_table_req('{op: t_op'(i_tuser), ch: i_tdata[6:0], last: i_tlast,
                                  sal: i_tdata[38:7]});
            if (o_tvalid && i_tready) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result status=%0d hash=%h sal=%h",
                             $time, o_tuser, o_tdata[31:0], o_tdata[63:32]);
                    errors++;
                end else begin
                    t_rsp x;
                    x = expected_rsps.pop_front();
                    if (o_tuser !== x.status) begin
                        $display("%0t: status expected %0d actual %0d", $time, x.status, o_tuser);
                        errors++;
                    end
                    if (o_tdata[31:0] !== x.hash) begin
                        $display("%0t: key_hash expected %h actual %h", $time, x.hash,
                                 o_tdata[31:0]);
                        errors++;
                    end
                    if (o_tdata[63:32] !== x.sal) begin
                        $display("%0t: found_salary expected %h actual %h", $time, x.sal,
                                 o_tdata[63:32]);
                        errors++;
                    end
                end
            end
            if (out_gap > 0) begin
                out_gap <= out_gap - 1;
                i_tready <= 1'b0;
            end else begin
                i_tready <= 1'b1;
                if ($urandom_range(0, 9) < 3) out_gap <= pick_gap();
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [ByteW-1:0] nm [MaxKey + 4];
        int len;
        int total;
        i_rst_n  = 1'b0;
        i_tvalid = 1'b0;
        i_tready = 1'b0;
        i_tdata  = '0;
        i_tuser  = '0;
        i_tlast  = 1'b0;
        name_len = 0;
        hash_acc = '0;
        name_ovf = 1'b0;
        for (int i = 0; i < NumEntries; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_len[i] = 0;
            tbl_sal[i] = '0;
        end
        for (int p = 0; p < 16; p++) begin
            pool_len[p] = (p == 0) ? 1 : (p == 1) ? MaxKey : $urandom_range(1, 6);
            for (int k = 0; k < MaxKey + 4; k++)
                pool_name[p][k] = (p == 2) ? 7'h7f : ByteW'($urandom_range(0, 3));
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, each op, spare selector, all-ones char, too long, miss
        queue_name(pool_name[0], 1, OP_SEARCH, 32'h0);
        queue_name(pool_name[0], 1, OP_PUT, 32'hffff_ffff);
        queue_name(pool_name[0], 1, OP_PUT, 32'h0);
        queue_name(pool_name[0], 1, OP_SPARE, 32'h1);
        queue_name(pool_name[1], MaxKey, OP_PUT, 32'h1234_5678);
        queue_name(pool_name[1], MaxKey, OP_SEARCH, 32'h0);
        queue_name(pool_name[2], 4, OP_PUT, 32'h8000_0000);
        for (int k = 0; k < MaxKey + 4; k++) nm[k] = 7'h55;
        queue_name(nm, MaxKey + 1, OP_PUT, 32'hdead_beef);
        queue_name(pool_name[0], 1, OP_DELETE, 32'h0);
        queue_name(pool_name[0], 1, OP_DELETE, 32'h0);
        queue_name(pool_name[2], 4, OP_SEARCH, 32'h0);

        // Random: mostly pool names, some fresh names to fill the table
        total = 0;
        while (total < 1650) begin
            int p;
            p = $urandom_range(0, 99);
            if (p < 60) begin
                int q;
                q = $urandom_range(0, 15);
                len = (q == 1 && $urandom_range(0, 9) != 0) ? 1 : pool_len[q];
                queue_name(pool_name[q], len, t_op'($urandom_range(0, 3)), $urandom);
            end else if (p < 95) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++) nm[k] = ByteW'($urandom_range(0, 127));
                queue_name(nm, len, ($urandom_range(0, 3) != 0) ? OP_PUT : OP_SEARCH,
                           $urandom);
            end else begin
                len = $urandom_range(MaxKey - 1, MaxKey + 3);
                for (int k = 0; k < len; k++) nm[k] = ByteW'($urandom_range(0, 127));
                queue_name(nm, len, t_op'($urandom_range(0, 3)), $urandom);
            end
            total += len;
        end

        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        wait (!i_tvalid);
        wait (expected_rsps.size() == 0);
        repeat (NumEntries * 2 + MaxKey * 4 + 20) @(posedge i_clk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/skvt_pkg.sv
src/skvt_ram.sv
src/string_key_value_table_core.sv
src/skvt_checker.sv
verif/tb_string_key_value_table_core.sv
